// ===== rtl/core/breakpoint_address_table_top_macros.svh =====
// assertion macros for the breakpoint address table
`ifndef BREAKPOINT_ADDRESS_TABLE_TOP_MACROS_SVH
`define BREAKPOINT_ADDRESS_TABLE_TOP_MACROS_SVH

// property that must hold at every clock edge out of reset
`define BAT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define BAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bat_pkg.sv =====
// shared types and codes of the breakpoint address table
package bat_pkg;

  localparam int ADDR_W = 32;
  localparam int POS_W  = 8;          // entry index, enough for up to 256 entries
  localparam int CNT_W  = POS_W + 1;  // count, enough to hold 256

  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_FULL       = 2'd1;
  localparam logic [1:0] ST_PRESENT    = 2'd2;
  localparam logic [1:0] ST_BAD_NUMBER = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] code_address;
    logic [7:0]        entry_number;
  } bat_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic       hit;
    logic [6:0] slot_number;
    logic [6:0] held_count;
  } bat_out_t;

  // command broadcast along the row of cells
  typedef struct packed {
    logic              shift;  // cells at or above pos take the upper neighbour's address
    logic              load;   // cell at pos takes wdata
    logic [POS_W-1:0]  pos;
    logic [ADDR_W-1:0] wdata;
  } bat_cmd_t;

endpackage

// ===== rtl/core/bat_cell.sv =====
// one entry of the address table: holds an address, compares and shifts
module bat_cell import bat_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  bat_cmd_t          cmd,
  input  logic [ADDR_W-1:0] upper_addr,
  input  logic              cmp_en,
  input  logic [ADDR_W-1:0] cmp_addr,
  output logic [ADDR_W-1:0] addr,
  output logic              match
);

  logic [ADDR_W-1:0] addr_r;
  logic              match_r;
  logic [POS_W-1:0]  my_pos;

  assign my_pos = POS_W'(IDX);

  always_ff @(posedge clk) begin
    if (cmd.shift && (my_pos >= cmd.pos)) begin
      addr_r <= upper_addr;
    end else if (cmd.load && (my_pos == cmd.pos)) begin
      addr_r <= cmd.wdata;
    end
    if (cmp_en) begin
      match_r <= (addr_r == cmp_addr);
    end
  end

  assign addr  = addr_r;
  assign match = match_r;

endmodule

// ===== rtl/core/breakpoint_address_table_top.sv =====
// breakpoint address table: row of address cells with a request sequencer
// an accepted transaction is registered with the cell compares, and its result is then
//   written to the output register; no new transaction is taken while one is busy or
//   the output stalls; the lowest match is picked and the row shifts or loads while busy
// reset: synchronous active-low reset clears the entry count and control flags;
//   cell contents are not cleared and are never read before they are written
`include "breakpoint_address_table_top_macros.svh"

module breakpoint_address_table_top import bat_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  bat_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output bat_out_t out_data
);

  localparam int CW = $clog2(ENTRIES + 1);

  logic              in_acc;
  logic              busy_r, busy_nxt;
  bat_in_t           req_r;
  logic [CW-1:0]     total_r, total_nxt;
  logic              out_vld_r, out_vld_nxt;
  bat_out_t          out_data_r, out_data_nxt;

  logic [ADDR_W-1:0] cell_addr [ENTRIES];
  logic [ENTRIES-1:0] match_w;
  logic [ENTRIES-1:0] live;
  logic [ENTRIES-1:0] m;
  logic [ENTRIES-1:0] first_hot;
  logic               any_hit;
  logic [POS_W-1:0]   hit_idx;
  bat_cmd_t           cmd;

  logic [CNT_W-1:0]   total_ext;
  logic [CNT_W-1:0]   num_ext;
  logic [CNT_W-1:0]   slot_c;
  logic [CNT_W-1:0]   held_c;
  logic [1:0]         status_c;
  logic               hit_c;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = busy_r || (out_vld_r && out_stall);

  // row of cells, each takes its upper neighbour's address on a shift; the last keeps its own
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [ADDR_W-1:0] upper;
    if (i == ENTRIES - 1) begin : g_last
      assign upper = cell_addr[i];
    end else begin : g_mid
      assign upper = cell_addr[i + 1];
    end
    bat_cell #(.IDX(i)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .upper_addr (upper),
      .cmp_en     (in_acc),
      .cmp_addr   (in_data.code_address),
      .addr       (cell_addr[i]),
      .match      (match_w[i])
    );
    assign live[i] = (CW'(i) < total_r);
  end

  // lowest match: isolate the lowest set bit, then encode it
  assign m         = match_w & live;
  assign first_hot = m & (~m + ENTRIES'(1));
  assign any_hit   = |m;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (first_hot[i]) begin
        hit_idx = hit_idx | POS_W'(i);
      end
    end
  end

  assign total_ext = CNT_W'(total_r);
  assign num_ext   = CNT_W'(req_r.entry_number);

  always_comb begin
    cmd       = '0;
    cmd.wdata = req_r.code_address;
    status_c  = ST_DONE;
    hit_c     = 1'b0;
    slot_c    = '0;
    total_nxt = total_r;
    unique case (req_r.req_type)
      REQ_ADD: begin
        if (total_r >= CW'(ENTRIES)) begin
          status_c = ST_FULL;
        end else if (any_hit) begin
          status_c = ST_PRESENT;
        end else begin
          cmd.load  = busy_r;
          cmd.pos   = POS_W'(total_ext);
          total_nxt = total_r + CW'(1);
          slot_c    = total_ext + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if ((num_ext == '0) || (num_ext > total_ext)) begin
          status_c = ST_BAD_NUMBER;
        end else begin
          cmd.shift = busy_r;
          cmd.pos   = POS_W'(num_ext - CNT_W'(1));
          total_nxt = total_r - CW'(1);
        end
      end
      REQ_CHECK: begin
        hit_c = any_hit;
        if (any_hit) begin
          slot_c = CNT_W'(hit_idx) + CNT_W'(1);
        end
      end
      default: begin
        status_c = ST_DONE;
      end
    endcase
  end

  assign held_c = CNT_W'(total_nxt);

  always_comb begin
    busy_nxt     = in_acc;
    out_vld_nxt  = busy_r || (out_vld_r && out_stall);
    out_data_nxt = out_data_r;
    if (busy_r) begin
      out_data_nxt.status      = status_c;
      out_data_nxt.hit         = hit_c;
      out_data_nxt.slot_number = slot_c[6:0];
      out_data_nxt.held_count  = held_c[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
      total_r   <= '0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
      if (busy_r) begin
        total_r <= total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_acc) begin
      req_r <= in_data;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  `BAT_ASSERT_ALWAYS(a_count_bound, total_r <= CW'(ENTRIES), "entry count above capacity")
  `BAT_ASSERT_NEXT(a_one_exec_cycle, busy_r, !busy_r && out_vld_r, "request not completed")
  `BAT_ASSERT_NEXT(a_count_steps, !busy_r, $stable(total_r), "count changed while idle")

endmodule
